// ===== rtl/triangle_tangent_bitangent_top_assert.svh =====
// Assertion helpers shared by the block's RTL files.
`ifndef TRIANGLE_TANGENT_BITANGENT_TOP_ASSERT_SVH
`define TRIANGLE_TANGENT_BITANGENT_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TTB_ASSERT_NOW(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define TTB_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== rtl/ttb_pkg.sv =====
`default_nettype none
package ttb_pkg;

    localparam int unsigned COORD_W    = 16;
    localparam int unsigned DELTA_W    = 17;
    localparam int unsigned PROD_W     = 34;
    localparam int unsigned ACC_W      = 35;
    localparam int unsigned DEN_W      = 34;
    localparam int unsigned DVD_W      = 55;
    localparam int unsigned REM_W      = 35;
    localparam int unsigned FRAC_SHIFT = 20;
    localparam int unsigned RES_W      = 32;
    localparam int unsigned NUM_RES    = 6;
    localparam int unsigned DIV_STEPS  = 55;
    localparam int unsigned STEP_W     = 6;
    localparam int unsigned PAIR_W     = 3;

    // Pair index: the determinant first, then three tangent and three bitangent numerators.
    localparam logic [PAIR_W-1:0] PAIR_DET  = 3'd0;
    localparam logic [PAIR_W-1:0] PAIR_LAST = 3'd6;

    // Vertex phase codes.
    localparam logic [1:0] PHASE_ZERO = 2'd0;
    localparam logic [1:0] PHASE_ONE  = 2'd1;
    localparam logic [1:0] PHASE_TWO  = 2'd2;
    localparam logic [1:0] PHASE_BAD  = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] tex_u;
        logic signed [COORD_W-1:0] tex_v;
    } ttb_in_t;

    typedef struct packed {
        logic signed [RES_W-1:0] tan_x;
        logic signed [RES_W-1:0] tan_y;
        logic signed [RES_W-1:0] tan_z;
        logic signed [RES_W-1:0] bitan_x;
        logic signed [RES_W-1:0] bitan_y;
        logic signed [RES_W-1:0] bitan_z;
        logic                    degenerate;
    } ttb_out_t;

    // One closed triangle: edge vectors and UV deltas.
    typedef struct packed {
        logic signed [DELTA_W-1:0] e1_x;
        logic signed [DELTA_W-1:0] e1_y;
        logic signed [DELTA_W-1:0] e1_z;
        logic signed [DELTA_W-1:0] e2_x;
        logic signed [DELTA_W-1:0] e2_y;
        logic signed [DELTA_W-1:0] e2_z;
        logic signed [DELTA_W-1:0] du1;
        logic signed [DELTA_W-1:0] dv1;
        logic signed [DELTA_W-1:0] du2;
        logic signed [DELTA_W-1:0] dv2;
    } ttb_job_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_ACC  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } ttb_state_t;

endpackage
`default_nettype wire

// ===== rtl/ttb_fifo.sv =====
`default_nettype none
`include "triangle_tangent_bitangent_top_assert.svh"
module ttb_fifo import ttb_pkg::*; #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire ttb_job_t push_job,
    output logic          full,
    input  wire logic     pop,
    output ttb_job_t      pop_job,
    output logic          not_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ttb_job_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_job   = mem_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `TTB_ASSERT_NOW(a_fifo_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_FULL)
    `TTB_ASSERT_NOW(a_fifo_no_overflow, aclk, aresetn, full, !push || pop)
    `TTB_ASSERT_NOW(a_fifo_no_underflow, aclk, aresetn, pop, not_empty)

endmodule
`default_nettype wire

// ===== rtl/ttb_front.sv =====
`default_nettype none
`include "triangle_tangent_bitangent_top_assert.svh"
module ttb_front import ttb_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire ttb_in_t s_data,
    output logic         push,
    output ttb_job_t     push_job,
    input  wire logic    fifo_full
);

    logic [1:0] phase_reg, phase_next;
    ttb_in_t    held0_reg;
    ttb_in_t    held1_reg;
    logic       closing;
    logic       accept;

    // The third vertex closes a triangle and needs room in the queue.
    assign closing = (phase_reg == PHASE_TWO);
    assign s_ready = !closing || !fifo_full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && closing;

    // Edge vectors and UV deltas relative to the first vertex.
    always_comb begin
        push_job.e1_x = DELTA_W'(held1_reg.pos_x) - DELTA_W'(held0_reg.pos_x);
        push_job.e1_y = DELTA_W'(held1_reg.pos_y) - DELTA_W'(held0_reg.pos_y);
        push_job.e1_z = DELTA_W'(held1_reg.pos_z) - DELTA_W'(held0_reg.pos_z);
        push_job.e2_x = DELTA_W'(s_data.pos_x) - DELTA_W'(held0_reg.pos_x);
        push_job.e2_y = DELTA_W'(s_data.pos_y) - DELTA_W'(held0_reg.pos_y);
        push_job.e2_z = DELTA_W'(s_data.pos_z) - DELTA_W'(held0_reg.pos_z);
        push_job.du1  = DELTA_W'(held1_reg.tex_u) - DELTA_W'(held0_reg.tex_u);
        push_job.dv1  = DELTA_W'(held1_reg.tex_v) - DELTA_W'(held0_reg.tex_v);
        push_job.du2  = DELTA_W'(s_data.tex_u) - DELTA_W'(held0_reg.tex_u);
        push_job.dv2  = DELTA_W'(s_data.tex_v) - DELTA_W'(held0_reg.tex_v);
    end

    // Phase advance on each accepted vertex.
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            case (phase_reg)
                PHASE_ZERO: phase_next = PHASE_ONE;
                PHASE_ONE:  phase_next = PHASE_TWO;
                PHASE_TWO:  phase_next = PHASE_ZERO;
                default:    phase_next = PHASE_ONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_ZERO;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // The first two vertices of a triangle are held.
    always_ff @(posedge aclk) begin
        if (accept && (phase_reg == PHASE_ZERO || phase_reg == PHASE_BAD)) begin
            held0_reg <= s_data;
        end
        if (accept && phase_reg == PHASE_ONE) begin
            held1_reg <= s_data;
        end
    end

    `TTB_ASSERT_NOW(a_front_phase_valid, aclk, aresetn, 1'b1, phase_reg != PHASE_BAD)
    `TTB_ASSERT_NEXT(a_front_push_wraps, aclk, aresetn, push, phase_reg == PHASE_ZERO)

endmodule
`default_nettype wire

// ===== rtl/ttb_back.sv =====
`default_nettype none
`include "triangle_tangent_bitangent_top_assert.svh"
module ttb_back import ttb_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     job_valid,
    input  wire ttb_job_t job_data,
    output logic          pop,
    output logic          m_valid,
    input  wire logic     m_ready,
    output ttb_out_t      m_data
);

    ttb_state_t               state_reg, state_next;
    ttb_job_t                 job_reg;
    logic [PAIR_W-1:0]        pair_reg;
    logic                     half_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     det_neg_reg;
    logic [DEN_W-1:0]         den_reg;
    logic                     neg_reg;
    logic [DVD_W-1:0]         dvd_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [DVD_W-1:0]         quo_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [RES_W-1:0]         res_reg [NUM_RES];
    logic                     degen_reg;
    logic                     m_valid_reg;
    ttb_out_t                 m_data_reg;

    logic signed [DELTA_W-1:0] op_a, op_b;
    logic signed [ACC_W-1:0]   diff;
    logic [ACC_W-1:0]          diff_neg;
    logic [DEN_W-1:0]          diff_abs;
    logic [REM_W-1:0]          rem_sh;
    logic                      quo_bit;
    logic [DVD_W-1:0]          quo_next;
    logic [RES_W-1:0]          sat_val;
    logic [PAIR_W-1:0]         res_idx;
    logic                      out_free;

    assign pop      = (state_reg == ST_IDLE) && job_valid;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign res_idx  = pair_reg - 1'b1;

    // Operand pair for the shared multiplier.
    always_comb begin
        case (pair_reg)
            3'd0: begin
                op_a = half_reg ? job_reg.du2 : job_reg.du1;
                op_b = half_reg ? job_reg.dv1 : job_reg.dv2;
            end
            3'd1: begin
                op_a = half_reg ? job_reg.dv1 : job_reg.dv2;
                op_b = half_reg ? job_reg.e2_x : job_reg.e1_x;
            end
            3'd2: begin
                op_a = half_reg ? job_reg.dv1 : job_reg.dv2;
                op_b = half_reg ? job_reg.e2_y : job_reg.e1_y;
            end
            3'd3: begin
                op_a = half_reg ? job_reg.dv1 : job_reg.dv2;
                op_b = half_reg ? job_reg.e2_z : job_reg.e1_z;
            end
            3'd4: begin
                op_a = half_reg ? job_reg.du2 : job_reg.du1;
                op_b = half_reg ? job_reg.e1_x : job_reg.e2_x;
            end
            3'd5: begin
                op_a = half_reg ? job_reg.du2 : job_reg.du1;
                op_b = half_reg ? job_reg.e1_y : job_reg.e2_y;
            end
            3'd6: begin
                op_a = half_reg ? job_reg.du2 : job_reg.du1;
                op_b = half_reg ? job_reg.e1_z : job_reg.e2_z;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Difference of the two products and its magnitude.
    assign diff     = acc_reg - ACC_W'(prod_reg);
    assign diff_neg = -diff;
    assign diff_abs = diff[ACC_W-1] ? diff_neg[DEN_W-1:0] : diff[DEN_W-1:0];

    // One restoring division step per cycle.
    always_comb begin
        rem_sh   = {rem_reg[REM_W-2:0], dvd_reg[DVD_W-1]};
        quo_bit  = (rem_sh >= REM_W'(den_reg));
        quo_next = {quo_reg[DVD_W-2:0], quo_bit};
    end

    // Saturate the rounded magnitude to the signed result range.
    always_comb begin
        if (neg_reg) begin
            if (quo_next > DVD_W'(33'h080000000)) begin
                sat_val = 32'h80000000;
            end else begin
                sat_val = -quo_next[RES_W-1:0];
            end
        end else begin
            if (quo_next > DVD_W'(32'h7FFFFFFF)) begin
                sat_val = 32'h7FFFFFFF;
            end else begin
                sat_val = quo_next[RES_W-1:0];
            end
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (half_reg) begin
                    if (pair_reg == PAIR_DET) begin
                        state_next = (diff == '0) ? ST_OUT : ST_MUL;
                    end else begin
                        state_next = ST_DIV;
                    end
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_DIV: begin
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = (pair_reg == PAIR_LAST) ? ST_OUT : ST_MUL;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                job_reg   <= job_data;
                pair_reg  <= PAIR_DET;
                half_reg  <= 1'b0;
                degen_reg <= 1'b0;
            end
            ST_MUL: begin
                prod_reg <= op_a * op_b;
            end
            ST_ACC: begin
                if (!half_reg) begin
                    acc_reg  <= ACC_W'(prod_reg);
                    half_reg <= 1'b1;
                end else begin
                    half_reg <= 1'b0;
                    if (pair_reg == PAIR_DET) begin
                        det_neg_reg <= diff[ACC_W-1];
                        den_reg     <= diff_abs;
                        pair_reg    <= pair_reg + 1'b1;
                        if (diff == '0) begin
                            degen_reg <= 1'b1;
                            for (int i = 0; i < NUM_RES; i++) begin
                                res_reg[i] <= '0;
                            end
                        end
                    end else begin
                        neg_reg  <= diff[ACC_W-1] ^ det_neg_reg;
                        dvd_reg  <= (DVD_W'(diff_abs) << FRAC_SHIFT) + DVD_W'(den_reg >> 1);
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        step_reg <= '0;
                    end
                end
            end
            ST_DIV: begin
                rem_reg  <= quo_bit ? (rem_sh - REM_W'(den_reg)) : rem_sh;
                quo_reg  <= quo_next;
                dvd_reg  <= dvd_reg << 1;
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    res_reg[res_idx] <= sat_val;
                    pair_reg         <= pair_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_data_reg.tan_x      <= res_reg[0];
                    m_data_reg.tan_y      <= res_reg[1];
                    m_data_reg.tan_z      <= res_reg[2];
                    m_data_reg.bitan_x    <= res_reg[3];
                    m_data_reg.bitan_y    <= res_reg[4];
                    m_data_reg.bitan_z    <= res_reg[5];
                    m_data_reg.degenerate <= degen_reg;
                end
            end
            default: begin
            end
        endcase
    end

    `TTB_ASSERT_NOW(a_back_state_onehot, aclk, aresetn, 1'b1, $onehot(state_reg))
    `TTB_ASSERT_NOW(a_back_div_bound, aclk, aresetn, state_reg == ST_DIV,
        step_reg < STEP_W'(DIV_STEPS) && pair_reg != PAIR_DET)
    `TTB_ASSERT_NOW(a_back_degen_zero, aclk, aresetn, m_valid_reg && m_data_reg.degenerate,
        m_data_reg.tan_x == '0 && m_data_reg.bitan_z == '0)

endmodule
`default_nettype wire

// ===== rtl/triangle_tangent_bitangent_top.sv =====
// Processing: one shared 17x17 multiplier forms each product pair, the determinant first,
// and one radix-2 divider produces each of the six outputs in turn; when the UV determinant
// is zero the divider is skipped and the result is flagged degenerate with zero outputs.
// The back end takes a new triangle only after handing the last result to its output register;
// vertices are taken one per cycle while the two-entry triangle queue has room.
// Reset: aresetn is synchronous, active low, and clears the vertex phase, queue and valids.
`default_nettype none
module triangle_tangent_bitangent_top import ttb_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire ttb_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output ttb_out_t      m_data
);

    logic     push;
    ttb_job_t push_job;
    logic     fifo_full;
    logic     pop;
    ttb_job_t pop_job;
    logic     job_valid;

    // Vertex gathering and edge formation.
    ttb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_job  (push_job),
        .fifo_full (fifo_full)
    );

    // Triangle queue between the two halves.
    ttb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (fifo_full),
        .pop       (pop),
        .pop_job   (pop_job),
        .not_empty (job_valid)
    );

    // Determinant, numerators and division.
    ttb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_data  (pop_job),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire
